// ===== sv/dda_pkg.sv =====
// Shared widths, command codes and controller/datapath interface structs
// for the DDA line pixel generator. No dependencies.
package dda_pkg;

    localparam int COORD_BITS = 11;
    localparam int FRAC_BITS  = 16;
    localparam int WIDTH_BITS = 12;
    localparam int ADDR_BITS  = 24;
    localparam int COLOR_BITS = 8;

    localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
    localparam int SLOPE_BITS = FRAC_BITS + 2;
    localparam int QUO_BITS   = FRAC_BITS + 1;
    localparam int PROD_BITS  = COORD_BITS + WIDTH_BITS;

    localparam logic [WIDTH_BITS-1:0] SCREEN_WIDTH_RESET = WIDTH_BITS'(640);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef logic [COORD_BITS-1:0]        coord_t;
    typedef logic [WIDTH_BITS-1:0]        width_t;
    typedef logic [ADDR_BITS-1:0]         addr_t;
    typedef logic [COLOR_BITS-1:0]        color_t;
    typedef logic signed [ACC_BITS-1:0]   acc_t;
    typedef logic signed [SLOPE_BITS-1:0] slope_t;
    typedef logic [QUO_BITS-1:0]          quo_t;
    typedef logic [PROD_BITS-1:0]         prod_t;

    typedef struct packed {
        logic load_line;
        logic div_start;
        logic load_step;
        logic load_out;
    } dda_cmd_t;

    typedef struct packed {
        logic is_start;
        logic zero_len;
        logic active;
        logic div_done;
        logic out_free;
    } dda_status_t;

endpackage

// ===== sv/dda_div.sv =====
// Iterative restoring divider for the slope: (amin << FRAC_BITS) / amaj.
// One quotient bit per cycle. Depends on dda_pkg.
module dda_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  dda_pkg::coord_t  amin,
    input  dda_pkg::coord_t  amaj,
    output dda_pkg::quo_t    quotient,
    output logic             done
);

    localparam int CNT_BITS = $clog2(dda_pkg::QUO_BITS);
    localparam int CB = dda_pkg::COORD_BITS;

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    dda_pkg::coord_t         rem_reg;
    dda_pkg::coord_t         div_reg;
    dda_pkg::quo_t           num_reg;
    dda_pkg::quo_t           quo_reg;

    logic [CB:0]             trial;
    logic                    fits;

    // Amin never exceeds amaj, so the quotient has at most QUO_BITS bits and
    // the upper numerator bits collapse into the initial remainder amin >> 1.
    assign trial = {rem_reg, num_reg[dda_pkg::QUO_BITS-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(dda_pkg::QUO_BITS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= amin >> 1;
            div_reg <= amaj;
            num_reg <= {amin[0], {dda_pkg::FRAC_BITS{1'b0}}};
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? CB'(trial - {1'b0, div_reg}) : CB'(trial);
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[dda_pkg::QUO_BITS-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== sv/dda_datapath.sv =====
// Datapath of the line generator: line setup, DDA state, address multiply,
// output register and the width register. Depends on dda_pkg and dda_div.
module dda_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dda_pkg::dda_cmd_t     cmd_in,
    output dda_pkg::dda_status_t  status,
    input  logic                  cfg_we,
    input  dda_pkg::width_t       cfg_wdata,
    input  logic                  cmd,
    input  dda_pkg::coord_t       start_col,
    input  dda_pkg::coord_t       start_row,
    input  dda_pkg::coord_t       end_col,
    input  dda_pkg::coord_t       end_row,
    input  dda_pkg::color_t       red,
    input  dda_pkg::color_t       green,
    input  dda_pkg::color_t       blue,
    output logic                  out_valid,
    input  logic                  out_stall,
    output dda_pkg::addr_t        byte_address,
    output dda_pkg::coord_t       pixel_col,
    output dda_pkg::coord_t       pixel_row,
    output dda_pkg::color_t       out_blue,
    output dda_pkg::color_t       out_green,
    output dda_pkg::color_t       out_red,
    output logic                  last
);

    localparam int CB = dda_pkg::COORD_BITS;

    // Line setup
    logic signed [CB:0]  dx, dy;
    dda_pkg::coord_t     adx, ady, amaj, amin;
    logic                maj_x, zero_len;

    assign dx       = $signed({1'b0, end_col}) - $signed({1'b0, start_col});
    assign dy       = $signed({1'b0, end_row}) - $signed({1'b0, start_row});
    assign adx      = dx[CB] ? CB'(-dx) : CB'(dx);
    assign ady      = dy[CB] ? CB'(-dy) : CB'(dy);
    assign maj_x    = adx > ady;
    assign zero_len = !maj_x && (ady == '0);
    assign amaj     = maj_x ? adx : ady;
    assign amin     = maj_x ? ady : adx;

    dda_pkg::quo_t quotient;
    logic          div_done;

    dda_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd_in.div_start),
        .amin     (amin),
        .amaj     (amaj),
        .quotient (quotient),
        .done     (div_done)
    );

    // DDA state
    logic                  active_reg;
    logic                  major_is_x_reg;
    logic                  backward_reg;
    logic                  minor_neg_reg;
    dda_pkg::coord_t       major_pos_reg, major_end_reg;
    dda_pkg::acc_t         acc_reg;
    dda_pkg::slope_t       slope_reg;
    dda_pkg::color_t       red_reg, green_reg, blue_reg;
    dda_pkg::width_t       screen_width_reg;

    dda_pkg::coord_t       minor, step_col, step_row, major_pos_next;
    dda_pkg::slope_t       slope_pos;

    assign minor          = acc_reg[dda_pkg::FRAC_BITS +: CB];
    assign step_col       = major_is_x_reg ? major_pos_reg : minor;
    assign step_row       = major_is_x_reg ? minor : major_pos_reg;
    assign major_pos_next = backward_reg ? major_pos_reg - 1'b1 : major_pos_reg + 1'b1;
    assign slope_pos      = dda_pkg::slope_t'({1'b0, quotient});

    // Step pipeline and output register
    dda_pkg::prod_t        prod_reg;
    dda_pkg::coord_t       col_reg, row_reg;
    logic                  fin_reg;
    logic                  out_valid_reg;
    dda_pkg::addr_t        addr_sum, addr_x3;

    assign addr_sum = dda_pkg::addr_t'(prod_reg) + dda_pkg::addr_t'(col_reg);
    assign addr_x3  = addr_sum + (addr_sum << 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            screen_width_reg <= dda_pkg::SCREEN_WIDTH_RESET;
        end
        else
        begin
            if (cfg_we)
                screen_width_reg <= cfg_wdata;
            if (cmd_in.load_line)
                active_reg <= !zero_len;
            else if (cmd_in.load_step && (major_pos_next == major_end_reg))
                active_reg <= 1'b0;
            if (cmd_in.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_in.load_line)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            if (!zero_len)
            begin
                major_is_x_reg <= maj_x;
                major_pos_reg  <= maj_x ? start_col : start_row;
                major_end_reg  <= maj_x ? end_col : end_row;
                backward_reg   <= maj_x ? dx[CB] : dy[CB];
                minor_neg_reg  <= maj_x ? dy[CB] : dx[CB];
                acc_reg        <= dda_pkg::acc_t'({1'b0, (maj_x ? start_row : start_col),
                                                   {dda_pkg::FRAC_BITS{1'b0}}});
            end
        end
        if (div_done)
            slope_reg <= minor_neg_reg ? -slope_pos : slope_pos;
        if (cmd_in.load_step)
        begin
            col_reg       <= step_col;
            row_reg       <= step_row;
            prod_reg      <= dda_pkg::prod_t'(step_row) * dda_pkg::prod_t'(screen_width_reg);
            fin_reg       <= major_pos_next == major_end_reg;
            acc_reg       <= acc_reg + dda_pkg::acc_t'(slope_reg);
            major_pos_reg <= major_pos_next;
        end
        if (cmd_in.load_out)
        begin
            byte_address <= addr_x3;
            pixel_col    <= col_reg;
            pixel_row    <= row_reg;
            out_blue     <= blue_reg;
            out_green    <= green_reg;
            out_red      <= red_reg;
            last         <= fin_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.is_start = cmd == dda_pkg::CMD_START;
    assign status.zero_len = zero_len;
    assign status.active   = active_reg;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || !out_stall;

endmodule

// ===== sv/dda_ctrl.sv =====
// Controller state machine of the line generator: input handshake and
// sequencing of setup, division and pixel output. Depends on dda_pkg.
module dda_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  dda_pkg::dda_status_t  status,
    output dda_pkg::dda_cmd_t     cmd_out
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd_out    = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (status.is_start)
                    begin
                        cmd_out.load_line = 1'b1;
                        if (!status.zero_len)
                        begin
                            cmd_out.div_start = 1'b1;
                            state_next        = ST_DIV;
                        end
                    end
                    else if (status.active)
                    begin
                        cmd_out.load_step = 1'b1;
                        state_next        = ST_OUT;
                    end
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd_out.load_out = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/dda_line_pixel_generator_top.sv =====
// Top level of the DDA line pixel generator: joins controller and datapath.
// Depends on dda_pkg, dda_ctrl, dda_datapath (and dda_div below it).

// A start request (cmd 0) loads two endpoints and a colour; the block then
// picks the major axis (x only when |dx| > |dy|) and forms a signed 2.16
// slope with a one-bit-per-cycle divider, so a start request holds the input
// through setup, the quotient bits and the slope write-back. A zero-length
// line does not start the divider and leaves the block idle. Each step request
// (cmd 1) while a line is active produces one pixel: first the accumulator
// advances and row times screen_width is registered, then the column is added,
// the sum is scaled by three and the output register is loaded once it is free.
// A step while idle is taken and produces nothing. The output register
// decouples the two sides: the next request is accepted while a pixel waits
// for the receiver, and a stalled receiver only delays the following step. The
// last flag marks the final pixel; the endpoint itself is never drawn. Write
// screen_width through cfg_we/cfg_wdata only while the block is idle.
module dda_line_pixel_generator_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  dda_pkg::width_t  cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             cmd,
    input  dda_pkg::coord_t  start_col,
    input  dda_pkg::coord_t  start_row,
    input  dda_pkg::coord_t  end_col,
    input  dda_pkg::coord_t  end_row,
    input  dda_pkg::color_t  red,
    input  dda_pkg::color_t  green,
    input  dda_pkg::color_t  blue,
    output logic             out_valid,
    input  logic             out_stall,
    output dda_pkg::addr_t   byte_address,
    output dda_pkg::coord_t  pixel_col,
    output dda_pkg::coord_t  pixel_row,
    output dda_pkg::color_t  out_blue,
    output dda_pkg::color_t  out_green,
    output dda_pkg::color_t  out_red,
    output logic             last
);

    dda_pkg::dda_cmd_t     ctrl_cmd;
    dda_pkg::dda_status_t  dp_status;

    // Sequence each request; the controller owns the input handshake.
    dda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (dp_status),
        .cmd_out  (ctrl_cmd)
    );

    // Hold line state, run the divider and drive the result register.
    dda_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_in       (ctrl_cmd),
        .status       (dp_status),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .start_col    (start_col),
        .start_row    (start_row),
        .end_col      (end_col),
        .end_row      (end_row),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_address (byte_address),
        .pixel_col    (pixel_col),
        .pixel_row    (pixel_row),
        .out_blue     (out_blue),
        .out_green    (out_green),
        .out_red      (out_red),
        .last         (last)
    );

    // Never overwrite a result that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.load_out |-> !(out_valid && out_stall))
        else $error("output register loaded while a stalled result waits");

    // The divider only starts on a line with a nonzero major length.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.div_start |-> (ctrl_cmd.load_line && !dp_status.zero_len))
        else $error("divider started without a valid line setup");

    // A step request advances the line only while it is active.
    a_step_active: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.load_step |-> (dp_status.active && !in_stall))
        else $error("step issued on an idle line");

    // After a step the input holds until the pixel is loaded.
    a_step_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.load_step |=> in_stall)
        else $error("input accepted while a pixel is in flight");

endmodule

// ===== bench/dda_pixel_checker.sv =====
// Pixel checker for the DDA line pixel generator: watches the request, result
// and configuration ports, predicts each pixel and compares it.
// Depends on dda_pkg.
module dda_pixel_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  dda_pkg::width_t  cfg_wdata,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic             cmd,
    input  dda_pkg::coord_t  start_col,
    input  dda_pkg::coord_t  start_row,
    input  dda_pkg::coord_t  end_col,
    input  dda_pkg::coord_t  end_row,
    input  dda_pkg::color_t  red,
    input  dda_pkg::color_t  green,
    input  dda_pkg::color_t  blue,
    input  logic             out_valid,
    input  logic             out_stall,
    input  dda_pkg::addr_t   byte_address,
    input  dda_pkg::coord_t  pixel_col,
    input  dda_pkg::coord_t  pixel_row,
    input  dda_pkg::color_t  out_blue,
    input  dda_pkg::color_t  out_green,
    input  dda_pkg::color_t  out_red,
    input  logic             last,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        dda_pkg::addr_t  addr;
        dda_pkg::coord_t col;
        dda_pkg::coord_t row;
        dda_pkg::color_t b;
        dda_pkg::color_t g;
        dda_pkg::color_t r;
        logic            fin;
    } pixel_t;

    pixel_t  pixel_queue[$];
    int      mismatches = 0;
    int      waiting    = 0;

    // Line walker state
    dda_pkg::width_t  pitch      = dda_pkg::SCREEN_WIDTH_RESET;
    logic             walking    = 1'b0;
    logic             x_major    = 1'b0;
    dda_pkg::coord_t  major_at   = '0;
    dda_pkg::coord_t  major_stop = '0;
    logic             walk_back  = 1'b0;
    longint           minor_acc  = 0;
    longint           slope_frac = 0;
    dda_pkg::color_t  col_b      = '0;
    dda_pkg::color_t  col_g      = '0;
    dda_pkg::color_t  col_r      = '0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    task automatic load_segment(dda_pkg::coord_t c0, dda_pkg::coord_t r0,
                                dda_pkg::coord_t c1, dda_pkg::coord_t r1,
                                dda_pkg::color_t rd, dda_pkg::color_t gr,
                                dda_pkg::color_t bl);
        int     dx, dy, adx, ady, dmaj, dmin, amaj, amin, minor0;
        longint q;
        dx = int'(c1) - int'(c0);
        dy = int'(r1) - int'(r0);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        col_b = bl;
        col_g = gr;
        col_r = rd;
        if (adx > ady)
        begin
            x_major = 1'b1;
            dmaj = dx; dmin = dy; amaj = adx; amin = ady;
            major_at = c0; major_stop = c1;
            minor0 = int'(r0);
        end
        else if (ady != 0)
        begin
            x_major = 1'b0;
            dmaj = dy; dmin = dx; amaj = ady; amin = adx;
            major_at = r0; major_stop = r1;
            minor0 = int'(c0);
        end
        else
        begin
            // zero-length line: nothing to draw
            walking = 1'b0;
            return;
        end
        q = (longint'(amin) << dda_pkg::FRAC_BITS) / longint'(amaj);
        slope_frac = (dmin < 0) ? -q : q;
        walk_back = (dmaj < 0);
        minor_acc = longint'(minor0) << dda_pkg::FRAC_BITS;
        walking = 1'b1;
    endtask

    task automatic advance_pixel();
        dda_pkg::coord_t minor;
        pixel_t          px;
        if (!walking)
            return;
        minor = dda_pkg::coord_t'(minor_acc >> dda_pkg::FRAC_BITS);
        px.col = x_major ? major_at : minor;
        px.row = x_major ? minor : major_at;
        px.addr = dda_pkg::addr_t'((longint'(px.row) * longint'(pitch)
                                    + longint'(px.col)) * 3);
        px.b = col_b;
        px.g = col_g;
        px.r = col_r;
        minor_acc = minor_acc + slope_frac;
        major_at = walk_back ? dda_pkg::coord_t'(major_at - 1)
                             : dda_pkg::coord_t'(major_at + 1);
        px.fin = (major_at == major_stop);
        if (px.fin)
            walking = 1'b0;
        pixel_queue.push_back(px);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t got, want;
        if (!rst_n)
        begin
            pitch = dda_pkg::SCREEN_WIDTH_RESET;
            walking = 1'b0;
            x_major = 1'b0;
            major_at = '0;
            major_stop = '0;
            walk_back = 1'b0;
            minor_acc = 0;
            slope_frac = 0;
            col_b = '0;
            col_g = '0;
            col_r = '0;
            pixel_queue.delete();
        end
        else
        begin
            if (cfg_we)
                pitch = cfg_wdata;
            if (in_valid && !in_stall)
            begin
                if (cmd == dda_pkg::CMD_START)
                    load_segment(start_col, start_row, end_col, end_row, red, green, blue);
                else
                    advance_pixel();
            end
            if (out_valid && !out_stall)
            begin
                got = '{byte_address, pixel_col, pixel_row, out_blue, out_green, out_red, last};
                if (pixel_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel: addr=%0d col=%0d row=%0d last=%0b",
                                 got.addr, got.col, got.row, got.fin);
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    if (got.addr !== want.addr || got.col !== want.col ||
                        got.row !== want.row || got.b !== want.b ||
                        got.g !== want.g || got.r !== want.r || got.fin !== want.fin)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"pixel mismatch: expected addr=%0d col=%0d row=%0d ",
                                      "bgr=%h%h%h last=%0b, got addr=%0d col=%0d row=%0d ",
                                      "bgr=%h%h%h last=%0b"},
                                     want.addr, want.col, want.row, want.b, want.g, want.r,
                                     want.fin, got.addr, got.col, got.row, got.b, got.g,
                                     got.r, got.fin);
                    end
                end
            end
        end
        waiting = pixel_queue.size();
    end

endmodule

// ===== bench/dda_line_pixel_generator_top_tb.sv =====
// Testbench top for the DDA line pixel generator: drives line and step
// requests plus screen_width writes, and gives the verdict.
// Depends on dda_pkg, dda_line_pixel_generator_top and dda_pixel_checker.
module dda_line_pixel_generator_top_tb;

    localparam int ITEM_TARGET   = 1400;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 400;
    // A start request holds the input while the divider runs; give the divider
    // and the two-stage pixel pipe comfortable room before touching config.
    localparam int SETTLE_CYCLES = 32;
    localparam int COORD_MAX     = (1 << dda_pkg::COORD_BITS) - 1;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    dda_pkg::width_t  cfg_wdata;
    logic             in_valid;
    logic             in_stall;
    logic             cmd;
    dda_pkg::coord_t  start_col, start_row, end_col, end_row;
    dda_pkg::color_t  red, green, blue;
    logic             out_valid;
    logic             out_stall;
    dda_pkg::addr_t   byte_address;
    dda_pkg::coord_t  pixel_col, pixel_row;
    dda_pkg::color_t  out_blue, out_green, out_red;
    logic             last;

    int      fail_count;
    int      pending;
    int      sent        = 0;
    int      cycle_count = 0;
    int      hold_count  = 0;
    logic    quiet       = 1'b0;   // no idling on either side while set
    logic    hold_go     = 1'b0;   // ask the receiver for its long hold-off
    logic    hold_done   = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dda_line_pixel_generator_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .start_col    (start_col),
        .start_row    (start_row),
        .end_col      (end_col),
        .end_row      (end_row),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_address (byte_address),
        .pixel_col    (pixel_col),
        .pixel_row    (pixel_row),
        .out_blue     (out_blue),
        .out_green    (out_green),
        .out_red      (out_red),
        .last         (last)
    );

    dda_pixel_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .start_col    (start_col),
        .start_row    (start_row),
        .end_col      (end_col),
        .end_row      (end_row),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_address (byte_address),
        .pixel_col    (pixel_col),
        .pixel_row    (pixel_row),
        .out_blue     (out_blue),
        .out_green    (out_green),
        .out_red      (out_red),
        .last         (last),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Receiver: stall at random with a probability of about 19 percent, never while
    // quiet is set. Once hold_go rises, hold off for HOLD_CYCLES in a row so
    // the output register and pipe fill and the block stalls its input.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                out_stall = 1'b1;
                hold_count++;
                if (hold_count >= HOLD_CYCLES)
                    hold_done = 1'b1;
            end
            else
            begin
                out_stall = !quiet && ($urandom_range(99) < 19);
            end
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Drop valid and keep it low; n sets how long the idle lasts.
    task automatic idle_for(int n);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Offer one request at the falling edge and hold it until accepted.
    // Valid stays high afterwards so back-to-back requests keep it up; the
    // next request or an idle call is the single update at the next edge.
    task automatic push_request(logic c, dda_pkg::coord_t c0, dda_pkg::coord_t r0,
                                dda_pkg::coord_t c1, dda_pkg::coord_t r1,
                                dda_pkg::color_t rd, dda_pkg::color_t gr,
                                dda_pkg::color_t bl);
        if (!quiet && $urandom_range(99) < 19)
            idle_for($urandom_range(1, 3));
        @(negedge clk);
        cmd       = c;
        start_col = c0;
        start_row = r0;
        end_col   = c1;
        end_row   = r1;
        red       = rd;
        green     = gr;
        blue      = bl;
        in_valid  = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // Step request; the payload is don't-care, so fill it with noise.
    task automatic push_step();
        push_request(dda_pkg::CMD_STEP, dda_pkg::coord_t'($urandom),
                     dda_pkg::coord_t'($urandom), dda_pkg::coord_t'($urandom),
                     dda_pkg::coord_t'($urandom), dda_pkg::color_t'($urandom),
                     dda_pkg::color_t'($urandom), dda_pkg::color_t'($urandom));
    endtask

    task automatic draw_line(dda_pkg::coord_t c0, dda_pkg::coord_t r0,
                             dda_pkg::coord_t c1, dda_pkg::coord_t r1,
                             dda_pkg::color_t rd, dda_pkg::color_t gr,
                             dda_pkg::color_t bl, int steps);
        push_request(dda_pkg::CMD_START, c0, r0, c1, r1, rd, gr, bl);
        repeat (steps) push_step();
    endtask

    // Endpoint near s, kept on screen by mirroring the offset.
    function automatic dda_pkg::coord_t near_coord(dda_pkg::coord_t s, int d);
        int e;
        e = int'(s) + d;
        if (e > COORD_MAX || e < 0)
            e = int'(s) - d;
        return dda_pkg::coord_t'(e);
    endfunction

    function automatic int line_span(dda_pkg::coord_t c0, dda_pkg::coord_t r0,
                                     dda_pkg::coord_t c1, dda_pkg::coord_t r1);
        int adx, ady;
        adx = int'(c0) - int'(c1);
        ady = int'(r0) - int'(r1);
        if (adx < 0) adx = -adx;
        if (ady < 0) ady = -ady;
        return (adx > ady) ? adx : ady;
    endfunction

    // Mostly complete lines with random geometry, some abandoned midway,
    // some zero-length, and some stray steps.
    task automatic random_line();
        int               kind, dmax, span, steps;
        dda_pkg::coord_t  c0, r0, c1, r1;
        kind = $urandom_range(99);
        if (kind >= 85 && kind < 95)
        begin
            push_step();
            return;
        end
        c0 = dda_pkg::coord_t'($urandom);
        r0 = dda_pkg::coord_t'($urandom);
        if (kind >= 95)
        begin
            draw_line(c0, r0, c0, r0, dda_pkg::color_t'($urandom),
                      dda_pkg::color_t'($urandom), dda_pkg::color_t'($urandom), 1);
            return;
        end
        dmax = ($urandom_range(19) == 0) ? 300 : 24;
        c1 = near_coord(c0, int'($urandom_range(2 * dmax)) - dmax);
        r1 = near_coord(r0, int'($urandom_range(2 * dmax)) - dmax);
        span = line_span(c0, r0, c1, r1);
        if (kind < 70)
            steps = span + $urandom_range(1);
        else
            steps = (span == 0) ? 0 : $urandom_range(span - 1);
        draw_line(c0, r0, c1, r1, dda_pkg::color_t'($urandom),
                  dda_pkg::color_t'($urandom), dda_pkg::color_t'($urandom), steps);
    endtask

    // Drop valid, wait for every pixel, then give the divider time to finish.
    task automatic settle();
        idle_for(1);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_pitch(dda_pkg::width_t w);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = w;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    initial
    begin
        int pitch_plan[6];
        int goal;
        pitch_plan = '{1, 2048, 4095, 0, -1, 640};
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        cmd       = dda_pkg::CMD_STEP;
        start_col = '0;
        start_row = '0;
        end_col   = '0;
        end_row   = '0;
        red       = '0;
        green     = '0;
        blue      = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed lines at the reset pitch.
        push_step();                                              // step while idle
        draw_line(0, 0, 3, 1, 8'hff, 8'h00, 8'hff, 3);            // shallow x-major
        push_step();                                              // line already done
        draw_line(10, 10, 13, 13, 8'h00, 8'hff, 8'h00, 3);        // tie goes to y
        draw_line(2047, 2047, 2044, 2045, 8'h12, 8'h34, 8'h56, 3); // backward, negative slope
        draw_line(5, 5, 5, 5, 8'hff, 8'hff, 8'hff, 1);            // zero length
        draw_line(0, 2047, 2047, 0, 8'h00, 8'h00, 8'h00, 2);      // corner diagonal, abandoned
        draw_line(2047, 0, 0, 1, 8'hab, 8'hcd, 8'hef, 2);         // full-width, abandoned
        draw_line(100, 0, 100, 2, 8'h80, 8'h7f, 8'h01, 2);        // vertical
        draw_line(0, 7, 2, 7, 8'hfe, 8'h01, 8'h80, 2);            // horizontal
        settle();

        // Random phases, one pitch each: minimum, nominal maximum, all ones
        // (address wraps), zero, random, back to reset.
        foreach (pitch_plan[p])
        begin
            settle();
            if (pitch_plan[p] < 0)
                write_pitch(dda_pkg::width_t'($urandom_range(1, 2048)));
            else
                write_pitch(dda_pkg::width_t'(pitch_plan[p]));
            quiet = (p == 1);
            if (p == 2)
            begin
                // Long receiver hold-off while a long line keeps the input busy.
                hold_go = 1'b1;
                draw_line(0, 0, 60, 13, 8'h55, 8'haa, 8'h5a, 40);
            end
            goal = sent + ITEM_TARGET / 6;
            while (sent < goal)
                random_line();
            quiet = 1'b0;
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
